/* design/smfc_pkg.sv */
// Shared constants, codes and types for the sensor module frame codec.
// No dependencies; compiled first.
package smfc_pkg;

  // Frame geometry
  localparam int FrameLen  = 8;
  localparam int FrameIdxW = $clog2(FrameLen);
  localparam int CntW      = FrameIdxW + 1;
  localparam int SendLen   = 7;
  localparam int SendIdxW  = $clog2(SendLen);

  // Header bytes
  localparam logic [7:0] Hdr0 = 8'h6C;
  localparam logic [7:0] Hdr1 = 8'h63;
  localparam logic [7:0] Hdr2 = 8'h62;

  // Input command codes
  localparam logic [1:0] CmdSend = 2'd0;
  localparam logic [1:0] CmdRx   = 2'd1;
  localparam logic [1:0] CmdIdle = 2'd2;
  localparam logic [1:0] CmdNone = 2'd3;

  // Result kinds
  localparam logic KindTx  = 1'b0;
  localparam logic KindChk = 1'b1;

  // Reply status codes, in check order
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StHdr0    = 3'd1;
  localparam logic [2:0] StHdr1    = 3'd2;
  localparam logic [2:0] StHdr2    = 3'd3;
  localparam logic [2:0] StCmd     = 3'd4;
  localparam logic [2:0] StRsvd    = 3'd5;
  localparam logic [2:0] StSum     = 3'd6;

  typedef logic [7:0] byte_t;
  typedef logic [FrameLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic [2:0] status;
    byte_t      result;
    byte_t      param;
  } reply_t;

endpackage

/* design/smfc_if.sv */
// Valid/ready channel interfaces for the frame codec's input and result sides.
// Standalone; widths follow the item fields.
interface smfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] cmd_code;
  logic [7:0] param_byte;
  logic [7:0] rx_byte;

  modport source (output valid, command, cmd_code, param_byte, rx_byte, input ready);
  modport sink   (input valid, command, cmd_code, param_byte, rx_byte, output ready);
endinterface

interface smfc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic [2:0] status;
  logic [7:0] reply_result;
  logic [7:0] reply_param;

  modport source (output valid, kind, tx_byte, last, status, reply_result, reply_param,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, status, reply_result, reply_param,
                  output ready);
endinterface

/* design/smfc_reply_chk.sv */
// Reply frame checker: ordered header, echo, reserved and checksum tests.
// Depends on smfc_pkg.
module smfc_reply_chk (
  input  smfc_pkg::frame_t frame,
  input  smfc_pkg::byte_t  sent_cmd,
  output smfc_pkg::reply_t reply
);

  smfc_pkg::byte_t sum;

  // Expected checksum over header pair, echoed command, result and parameter
  assign sum = smfc_pkg::Hdr1 + smfc_pkg::Hdr2 + sent_cmd + frame[5] + frame[4];

  // First failing check sets the status
  always_comb begin
    reply.status = smfc_pkg::StOk;
    reply.result = frame[4];
    reply.param  = frame[5];
    if (frame[0] != smfc_pkg::Hdr0) begin
      reply.status = smfc_pkg::StHdr0;
    end else if (frame[1] != smfc_pkg::Hdr2) begin
      reply.status = smfc_pkg::StHdr1;
    end else if (frame[2] != smfc_pkg::Hdr1) begin
      reply.status = smfc_pkg::StHdr2;
    end else if (frame[3] != sent_cmd) begin
      reply.status = smfc_pkg::StCmd;
    end else if (frame[6] != 8'h00) begin
      reply.status = smfc_pkg::StRsvd;
    end else if (frame[7] != sum) begin
      reply.status = smfc_pkg::StSum;
    end
    // Result and parameter only accompany checks past the command echo
    if (reply.status == smfc_pkg::StHdr0 || reply.status == smfc_pkg::StHdr1 ||
        reply.status == smfc_pkg::StHdr2 || reply.status == smfc_pkg::StCmd) begin
      reply.result = 8'h00;
      reply.param  = 8'h00;
    end
  end

endmodule

/* design/sensor_module_frame_codec_unit.sv */
// Top level of the sensor module frame codec: frame store memory, job stage,
// output register. Depends on smfc_pkg, smfc_if and smfc_reply_chk.
//
//   channel  | dir | fields
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | command, cmd_code, param_byte, rx_byte
//   out_ch   | out | kind, tx_byte, last, status, reply_result, reply_param
//
// A received byte or an unused code is taken without starting a job; an idle
// item starts a check job whose result is loaded into the output register.
// A send item occupies the job stage for its seven transmitted bytes, one
// output item each, so the job stage and the output register set the rate.
// rst_n is synchronous, active low; it clears the count, valid bits and
// the stored command. A stalled output holds a waiting job and blocks input.
module sensor_module_frame_codec_unit (
  input  logic              clk,
  input  logic              rst_n,
  smfc_in_if.sink           in_ch,
  smfc_out_if.source        out_ch
);

  // Frame store memory and its state
  smfc_pkg::byte_t                   frame_mem [smfc_pkg::FrameLen];
  logic [smfc_pkg::FrameLen-1:0]     vld_r, vld_nxt;
  logic [smfc_pkg::CntW-1:0]         cnt_r, cnt_nxt;
  smfc_pkg::byte_t                   lsc_r, lsc_nxt;

  // Job stage
  logic                              job_v_r, job_v_nxt;
  logic                              job_send_r;
  logic [smfc_pkg::SendIdxW-1:0]     job_idx_r, job_idx_nxt;
  smfc_pkg::byte_t                   job_cmd_r;
  smfc_pkg::byte_t                   job_par_r;
  smfc_pkg::frame_t                  job_frame_r;
  smfc_pkg::byte_t                   job_lsc_r;

  // Output register
  logic                              out_v_r, out_v_nxt;
  logic                              out_kind_r;
  smfc_pkg::byte_t                   out_tx_r;
  logic                              out_last_r;
  logic [2:0]                        out_status_r;
  smfc_pkg::byte_t                   out_res_r;
  smfc_pkg::byte_t                   out_par_r;

  logic                              in_acc;
  logic                              rx_wr;
  logic                              out_load;
  logic                              job_fin;
  logic                              job_last_byte;
  smfc_pkg::byte_t                   tx_sel;
  smfc_pkg::reply_t                  reply;

  // Handshake
  assign out_load      = job_v_r && (!out_v_r || out_ch.ready);
  assign job_last_byte = (job_idx_r == smfc_pkg::SendIdxW'(smfc_pkg::SendLen - 1));
  assign job_fin       = out_load && (!job_send_r || job_last_byte);
  assign in_ch.ready   = !job_v_r || job_fin;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign rx_wr         = in_acc && (in_ch.command == smfc_pkg::CmdRx) &&
                         (cnt_r < smfc_pkg::CntW'(smfc_pkg::FrameLen));

  // Check the captured reply
  smfc_reply_chk u_chk (
    .frame    (job_frame_r),
    .sent_cmd (job_lsc_r),
    .reply    (reply)
  );

  // Select the transmit byte for the current send position
  always_comb begin
    case (job_idx_r)
      3'd0:    tx_sel = smfc_pkg::Hdr0;
      3'd1:    tx_sel = smfc_pkg::Hdr1;
      3'd2:    tx_sel = smfc_pkg::Hdr2;
      3'd3:    tx_sel = job_cmd_r;
      3'd4:    tx_sel = job_par_r;
      3'd5:    tx_sel = 8'h00;
      default: tx_sel = smfc_pkg::Hdr1 + smfc_pkg::Hdr2 + job_cmd_r + job_par_r;
    endcase
  end

  // Next-state logic for control registers
  always_comb begin
    vld_nxt     = vld_r;
    cnt_nxt     = cnt_r;
    lsc_nxt     = lsc_r;
    job_v_nxt   = job_v_r;
    job_idx_nxt = job_idx_r;
    out_v_nxt   = out_v_r;

    // Advance or retire the job
    if (job_fin) begin
      job_v_nxt = 1'b0;
    end else if (out_load) begin
      job_idx_nxt = job_idx_r + 1'b1;
    end

    // Output register: load or drop after transfer
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    if (rx_wr) begin
      vld_nxt[cnt_r[smfc_pkg::FrameIdxW-1:0]] = 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end

    if (in_acc) begin
      case (in_ch.command)
        smfc_pkg::CmdSend: begin
          lsc_nxt     = in_ch.cmd_code;
          job_v_nxt   = 1'b1;
          job_idx_nxt = '0;
        end
        smfc_pkg::CmdIdle: begin
          cnt_nxt     = '0;
          job_v_nxt   = 1'b1;
          job_idx_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      cnt_r     <= '0;
      lsc_r     <= '0;
      job_v_r   <= 1'b0;
      job_idx_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      cnt_r     <= cnt_nxt;
      lsc_r     <= lsc_nxt;
      job_v_r   <= job_v_nxt;
      job_idx_r <= job_idx_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Frame store write port
  always_ff @(posedge clk) begin
    if (rx_wr) begin
      frame_mem[cnt_r[smfc_pkg::FrameIdxW-1:0]] <= in_ch.rx_byte;
    end
  end

  // Job payload; an idle transfer reads the whole frame row into the job
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.command == smfc_pkg::CmdSend) begin
      job_send_r <= 1'b1;
      job_cmd_r  <= in_ch.cmd_code;
      job_par_r  <= in_ch.param_byte;
    end else if (in_acc && in_ch.command == smfc_pkg::CmdIdle) begin
      job_send_r <= 1'b0;
      job_lsc_r  <= lsc_r;
      for (int i = 0; i < smfc_pkg::FrameLen; i++) begin
        job_frame_r[i] <= vld_r[i] ? frame_mem[i] : 8'h00;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (job_send_r) begin
        out_kind_r   <= smfc_pkg::KindTx;
        out_tx_r     <= tx_sel;
        out_last_r   <= job_last_byte;
        out_status_r <= smfc_pkg::StOk;
        out_res_r    <= 8'h00;
        out_par_r    <= 8'h00;
      end else begin
        out_kind_r   <= smfc_pkg::KindChk;
        out_tx_r     <= 8'h00;
        out_last_r   <= 1'b1;
        out_status_r <= reply.status;
        out_res_r    <= reply.result;
        out_par_r    <= reply.param;
      end
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.tx_byte      = out_tx_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.reply_result = out_res_r;
  assign out_ch.reply_param  = out_par_r;

  // Assertions
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= smfc_pkg::CntW'(smfc_pkg::FrameLen))
    else $error("byte count past frame length");

  a_idle_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == smfc_pkg::CmdIdle |=> job_v_r && !job_send_r && cnt_r == '0)
    else $error("idle transfer did not start a check job");

  a_send_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == smfc_pkg::CmdSend |=> lsc_r == $past(in_ch.cmd_code))
    else $error("sent command not remembered");

  a_chk_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_kind_r == smfc_pkg::KindChk |-> out_last_r && out_tx_r == 8'h00)
    else $error("check result without last flag");

endmodule
